[rtl/core/mchw_pkg.sv]
package mchw_pkg;

  localparam int CHANNELS = 8;
  localparam int AGE_BITS = 16;
  localparam int CH_BITS  = 3;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [2:0] {
    CMD_REGISTER = 3'd0,
    CMD_HEARTBEAT = 3'd1,
    CMD_TICK = 3'd2,
    CMD_RECOVERY_DONE = 3'd3,
    CMD_TRIGGER = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    EV_ACK = 3'd0,
    EV_RECOVERED = 3'd1,
    EV_UNHEALTHY = 3'd2,
    EV_NOT_REGISTERED = 3'd3,
    EV_LIMIT = 3'd4,
    EV_STATUS = 3'd5
  } event_t;

  localparam logic [1:0] CFG_MONITOR_ENABLE = 2'd0;
  localparam logic [1:0] CFG_CHECK_INTERVAL = 2'd1;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  channel;
    logic [15:0] timeout_secs;
    logic [7:0]  restart_limit;
    logic        success;
  } in_word_t;

  typedef struct packed {
    logic [2:0] out_channel;
    logic [2:0] event_res;
    logic       alive;
    logic [7:0] restarts;
    logic       recovery_request;
    logic [7:0] unhealthy_mask;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [0:0]  index;
    logic [11:0] data;
  } cfg_word_t;

  // Decoded command handed from the front to the back.
  typedef struct packed {
    logic        is_tick;
    logic        check;
    in_word_t    word;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } back_state_t;

endpackage

[rtl/core/multi_channel_heartbeat_watchdog.sv]
// Heartbeat watchdog for eight channels. Command words enter a two-entry
// queue; a back end executes them one at a time. Register, heartbeat,
// recovery, trigger and query words are each executed once the result slot
// is free and give one result word. A tick passes through a start state, a
// walk over the channel entries one per cycle, and a finish state. It emits
// one word per channel that goes unhealthy (none if none does), and the walk
// stalls whenever a further unhealthy word finds the result slot still
// occupied. The final word of an item carries last.
// Configuration writes are always ready and should only be made while no
// command word is in flight.
module multi_channel_heartbeat_watchdog (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mchw_pkg::in_word_t  in_word,
  output logic                empty,
  input  logic                pop,
  output mchw_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [11:0]         cfg_data
);

  logic           job_valid;
  logic           job_take;
  mchw_pkg::job_t job;

  // Front end: intake, configuration and interval counting.
  mchw_front u_front (
    .clk, .rst, .push, .full, .in_word,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .job_valid, .job_take, .job
  );

  // Back end: channel state and result generation.
  mchw_back u_back (
    .clk, .rst, .job_valid, .job_take, .job,
    .empty, .pop, .out_word
  );

endmodule

[rtl/core/mchw_front.sv]
module mchw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mchw_pkg::in_word_t in_word,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [11:0]       cfg_data,
  output logic              job_valid,
  input  logic              job_take,
  output mchw_pkg::job_t    job
);

  // Two-entry job queue.
  mchw_pkg::job_t q [2];
  logic [1:0] count;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       monitor_enable;
  logic [11:0] check_interval;
  logic [11:0] interval_count;
  logic [11:0] interval_count_next;
  logic [11:0] lim;
  logic        check;
  logic        accept;
  logic        valid_cmd;

  assign full = (count == 2'd2);
  assign cfg_ready = 1'b1;
  assign valid_cmd = (in_word.command <= mchw_pkg::CMD_QUERY);
  assign accept = push && !full;
  assign job_valid = (count != 2'd0);
  assign job = q[rd_ptr];

  // Interval counter is tracked here so the back only sees a check flag.
  always_comb begin
    lim = (check_interval == 12'd0) ? 12'd1 : check_interval;
    interval_count_next = interval_count + 12'd1;
    check = 1'b0;
    if (!monitor_enable) begin
      interval_count_next = 12'd0;
    end else if (interval_count_next >= lim || interval_count_next == 12'd0) begin
      interval_count_next = 12'd0;
      check = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      monitor_enable <= 1'b0;
      check_interval <= 12'd1;
      interval_count <= 12'd0;
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == mchw_pkg::CFG_MONITOR_ENABLE) begin
          monitor_enable <= cfg_data[0];
        end else if (cfg_index == mchw_pkg::CFG_CHECK_INTERVAL) begin
          check_interval <= cfg_data;
        end
      end
      if (accept && valid_cmd && in_word.command == mchw_pkg::CMD_TICK) begin
        interval_count <= interval_count_next;
      end
      if (accept && valid_cmd) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept && valid_cmd} - {1'b0, job_take};
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (accept && valid_cmd) begin
      q[wr_ptr].word <= in_word;
      q[wr_ptr].is_tick <= (in_word.command == mchw_pkg::CMD_TICK);
      q[wr_ptr].check <= check;
    end
  end

endmodule

[rtl/core/mchw_back.sv]
module mchw_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_take,
  input  mchw_pkg::job_t     job,
  output logic               empty,
  input  logic               pop,
  output mchw_pkg::out_word_t out_word
);

  logic [mchw_pkg::CHANNELS-1:0] registered;
  logic [mchw_pkg::CHANNELS-1:0] alive_flag;
  logic [mchw_pkg::AGE_BITS-1:0] heartbeat_age [mchw_pkg::CHANNELS];
  logic [15:0] timeout_value [mchw_pkg::CHANNELS];
  logic [7:0]  restart_max [mchw_pkg::CHANNELS];
  logic [7:0]  restart_count [mchw_pkg::CHANNELS];

  mchw_pkg::back_state_t state, state_next;
  logic [2:0] idx;
  logic       have_pend;
  mchw_pkg::out_word_t pend;
  logic       out_full;

  logic [2:0] c;
  logic       known;
  logic [7:0] umask;
  logic [7:0] trip_ahead;
  logic [7:0] mask_after;
  logic [mchw_pkg::AGE_BITS-1:0] age_inc;
  logic       trip;
  logic       scan_done;
  logic       can_emit;
  logic       scan_stall;

  assign c = job.word.channel;
  assign known = registered[c];
  assign empty = !out_full;
  assign age_inc = (heartbeat_age[idx] == mchw_pkg::AGE_MAX) ? heartbeat_age[idx]
                   : heartbeat_age[idx] + 1'b1;
  assign trip = job.check && registered[idx] && alive_flag[idx] &&
                ({{(32-mchw_pkg::AGE_BITS){1'b0}}, age_inc} > {16'd0, timeout_value[idx]});
  assign scan_done = (idx == 3'd7);
  // Pending result may be released once output slot is free.
  assign can_emit = !out_full || pop;
  // The walk waits only when a held word must go out and the slot is busy.
  assign scan_stall = have_pend && trip && !can_emit;

  // Unhealthy mask computed from live state.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      umask[i] = registered[i] && !alive_flag[i];
    end
  end

  // Channels not yet walked are judged ahead, so every word of a tick
  // carries the mask as it stands once the whole tick is done.
  always_comb begin
    logic [mchw_pkg::AGE_BITS-1:0] age_next;
    age_next = '0;
    for (int i = 0; i < 8; i++) begin
      age_next = (heartbeat_age[i] == mchw_pkg::AGE_MAX) ? heartbeat_age[i]
                 : heartbeat_age[i] + 1'b1;
      trip_ahead[i] = (state == mchw_pkg::ST_SCAN) && job.check && (i >= int'(idx)) &&
                      registered[i] && alive_flag[i] &&
                      ({{(32-mchw_pkg::AGE_BITS){1'b0}}, age_next} >
                       {16'd0, timeout_value[i]});
    end
  end

  assign mask_after = umask | trip_ahead;

  always_comb begin
    state_next = state;
    job_take = 1'b0;
    case (state)
      mchw_pkg::ST_IDLE: begin
        if (job_valid && !have_pend) begin
          if (job.is_tick) begin
            state_next = mchw_pkg::ST_SCAN;
          end else if (can_emit) begin
            job_take = 1'b1;
          end
        end
      end
      mchw_pkg::ST_SCAN: begin
        if (!scan_stall && scan_done) begin
          state_next = mchw_pkg::ST_FLUSH;
        end
      end
      mchw_pkg::ST_FLUSH: begin
        if (!have_pend || can_emit) begin
          state_next = mchw_pkg::ST_IDLE;
          job_take = 1'b1;
        end
      end
      default: state_next = mchw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mchw_pkg::ST_IDLE;
      registered <= '0;
      alive_flag <= '0;
      idx <= 3'd0;
      have_pend <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (pop && out_full) begin
        out_full <= 1'b0;
      end
      case (state)
        mchw_pkg::ST_IDLE: begin
          idx <= 3'd0;
          if (job_take) begin
            out_full <= 1'b1;
            out_word.out_channel <= c;
            out_word.recovery_request <= 1'b0;
            out_word.last <= 1'b1;
            out_word.alive <= 1'b0;
            out_word.restarts <= 8'd0;
            out_word.event_res <= mchw_pkg::EV_NOT_REGISTERED;
            out_word.unhealthy_mask <= umask;
            if (job.word.command == mchw_pkg::CMD_REGISTER) begin
              registered[c] <= 1'b1;
              alive_flag[c] <= 1'b1;
              heartbeat_age[c] <= '0;
              timeout_value[c] <= job.word.timeout_secs;
              restart_max[c] <= job.word.restart_limit;
              restart_count[c] <= 8'd0;
              out_word.event_res <= mchw_pkg::EV_ACK;
              out_word.alive <= 1'b1;
              out_word.unhealthy_mask <= umask & ~(8'd1 << c);
            end else if (known) begin
              out_word.alive <= alive_flag[c];
              out_word.restarts <= restart_count[c];
              case (job.word.command)
                mchw_pkg::CMD_HEARTBEAT: begin
                  heartbeat_age[c] <= '0;
                  out_word.event_res <= mchw_pkg::EV_ACK;
                  if (!alive_flag[c]) begin
                    alive_flag[c] <= 1'b1;
                    restart_count[c] <= 8'd0;
                    out_word.event_res <= mchw_pkg::EV_RECOVERED;
                    out_word.alive <= 1'b1;
                    out_word.restarts <= 8'd0;
                    out_word.unhealthy_mask <= umask & ~(8'd1 << c);
                  end
                end
                mchw_pkg::CMD_RECOVERY_DONE: begin
                  out_word.event_res <= mchw_pkg::EV_ACK;
                  if (job.word.success) begin
                    alive_flag[c] <= 1'b1;
                    heartbeat_age[c] <= '0;
                    out_word.event_res <= mchw_pkg::EV_RECOVERED;
                    out_word.alive <= 1'b1;
                    out_word.unhealthy_mask <= umask & ~(8'd1 << c);
                  end
                end
                mchw_pkg::CMD_TRIGGER: begin
                  if (restart_count[c] >= restart_max[c]) begin
                    out_word.event_res <= mchw_pkg::EV_LIMIT;
                  end else begin
                    restart_count[c] <= restart_count[c] + 8'd1;
                    out_word.restarts <= restart_count[c] + 8'd1;
                    out_word.recovery_request <= 1'b1;
                    out_word.event_res <= mchw_pkg::EV_ACK;
                  end
                end
                default: begin
                  out_word.event_res <= mchw_pkg::EV_STATUS;
                end
              endcase
            end
          end
        end
        mchw_pkg::ST_SCAN: begin
          if (!scan_stall) begin
            // A new unhealthy channel means the held word is not the last one.
            if (have_pend && trip) begin
              out_full <= 1'b1;
              out_word <= pend;
              out_word.unhealthy_mask <= mask_after;
              out_word.last <= 1'b0;
            end
            idx <= idx + 3'd1;
            if (registered[idx]) begin
              heartbeat_age[idx] <= age_inc;
            end
            if (trip) begin
              alive_flag[idx] <= 1'b0;
              have_pend <= 1'b1;
              pend.out_channel <= idx;
              pend.event_res <= mchw_pkg::EV_UNHEALTHY;
              pend.alive <= 1'b0;
              pend.last <= 1'b1;
              pend.unhealthy_mask <= '0;
              if (restart_count[idx] < restart_max[idx]) begin
                restart_count[idx] <= restart_count[idx] + 8'd1;
                pend.restarts <= restart_count[idx] + 8'd1;
                pend.recovery_request <= 1'b1;
              end else begin
                pend.restarts <= restart_count[idx];
                pend.recovery_request <= 1'b0;
              end
            end
          end
        end
        mchw_pkg::ST_FLUSH: begin
          if (have_pend && can_emit) begin
            out_full <= 1'b1;
            out_word <= pend;
            out_word.unhealthy_mask <= mask_after;
            out_word.last <= 1'b1;
            have_pend <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
